### hdl/first_fit_free_list_allocator_core_assert.svh
// Assertion macros used by the allocator datapath.
// Expects clk_i and rst_ni to exist in the module that uses them.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH

// A condition that holds at every clock edge out of reset.
`define FFA_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("allocator assertion failed");

// An implication within the same cycle.
`define FFA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

`endif

### hdl/ffa_pkg.sv
// Package of the first-fit allocator: sizes, codes and the
// controller/datapath command and status types. No dependencies.
`default_nettype none

package ffa_pkg;

  localparam int FREE_SLOTS = 64;
  localparam int SLOT_BITS  = $clog2(FREE_SLOTS);
  localparam int CNT_BITS   = $clog2(FREE_SLOTS + 2);
  localparam int OFF_BITS   = 32;
  localparam int ALIGN_BITS = 9;
  localparam int ENTRY_BITS = 2 * OFF_BITS;
  localparam int MEM_AW     = SLOT_BITS + 2;
  localparam int MEM_DEPTH  = 4 * FREE_SLOTS;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 32;

  localparam int REM_DIGITS   = 4;
  localparam int REM_STEPS    = OFF_BITS / REM_DIGITS;
  localparam int REM_CNT_BITS = $clog2(REM_STEPS);

  localparam logic [OFF_BITS-1:0] OFF_MASK  = {OFF_BITS{1'b1}};
  localparam logic [OFF_BITS-1:0] CAP_RESET = OFF_BITS'(64 * 1024 * 1024);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic POOL_INDEX  = 1'b0;
  localparam logic POOL_VERTEX = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_VERTEX_CAP = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INDEX_CAP  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_NO_SPACE,
    STATUS_LIST_FULL
  } status_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_RD_ENTRY,
    OP_LATCH_CUR,
    OP_ALLOC_CHK,
    OP_MV_RD,
    OP_MV_WR,
    OP_W_LEAD,
    OP_W_TRAIL,
    OP_T_START,
    OP_T_CHK,
    OP_F_INS,
    OP_F_PUSH,
    OP_F_END,
    OP_F_FLUSH,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic count_zero;
    logic rem_busy;
    logic fit;
    logic split_full;
    logic idx_last;
    logic mv_done;
  } dp_stat_t;

endpackage

`default_nettype wire

### hdl/ffa_req_if.sv
// Request channel of the allocator: valid/ready plus one request beat.
// Uses ffa_pkg for field widths.
`default_nettype none

interface ffa_req_if;
  logic                             valid;
  logic                             ready;
  logic                             cmd;
  logic                             pool_select;
  logic [ffa_pkg::OFF_BITS-1:0]     byte_count;
  logic [ffa_pkg::ALIGN_BITS-1:0]   align_bytes;
  logic [ffa_pkg::OFF_BITS-1:0]     release_offset;

  modport source (output valid, cmd, pool_select, byte_count, align_bytes, release_offset,
                  input ready);
  modport sink (input valid, cmd, pool_select, byte_count, align_bytes, release_offset,
                output ready);
endinterface

`default_nettype wire

### hdl/ffa_rsp_if.sv
// Response channel of the allocator: valid/ready plus one result beat.
// Uses ffa_pkg for field widths.
`default_nettype none

interface ffa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     status;
  logic [ffa_pkg::OFF_BITS-1:0]   granted_offset;
  logic [ffa_pkg::CNT_BITS-1:0]   free_blocks;

  modport source (output valid, status, granted_offset, free_blocks, input ready);
  modport sink (input valid, status, granted_offset, free_blocks, output ready);
endinterface

`default_nettype wire

### hdl/first_fit_free_list_allocator_core.sv
// Top level of the two-pool first-fit allocator with coalescing free lists.
// Depends on ffa_pkg, ffa_req_if, ffa_rsp_if, ffa_ctrl and ffa_datapath.
`default_nettype none

// One request is in work at a time; a finished result waits in an output
// register while the next request is taken. An allocation reads the free-list
// entries in turn, each with a registered memory read and a remainder for the
// alignment rounding (4 quotient bits a cycle), moves entries when a split grows
// or shrinks the list, and tries the tail when no entry fits. A free reads and
// merges every list entry in turn. Each pool holds its list in two banks of 64
// entries; a free rebuilds the merged list in the spare bank and switches to it
// only when the result fits. No clearing pass follows reset.
module first_fit_free_list_allocator_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  ffa_req_if.sink                             req_i,
  ffa_rsp_if.source                           rsp_o,
  input  logic                                cfg_we_i,
  input  logic [ffa_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [ffa_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);

  ffa_pkg::dp_cmd_t  dp_cmd;
  ffa_pkg::dp_stat_t dp_stat;
  ffa_pkg::status_e  out_status;

  ffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  ffa_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .req_cmd_i     (req_i.cmd),
    .req_pool_i    (req_i.pool_select),
    .req_bytes_i   (req_i.byte_count),
    .req_align_i   (req_i.align_bytes),
    .req_offset_i  (req_i.release_offset),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .out_status_o  (out_status),
    .out_granted_o (rsp_o.granted_offset),
    .out_blocks_o  (rsp_o.free_blocks)
  );

  assign rsp_o.status = out_status;

endmodule

`default_nettype wire

### hdl/ffa_rem_unit.sv
// Iterative remainder unit: value modulo alignment, four quotient bits per cycle.
// Uses ffa_pkg for widths.
`default_nettype none

module ffa_rem_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [ffa_pkg::OFF_BITS-1:0]   value_i,
  input  logic [ffa_pkg::ALIGN_BITS-1:0] div_i,
  output logic                           busy_o,
  output logic [ffa_pkg::ALIGN_BITS-1:0] rem_o
);

  logic                             busy_q, busy_d;
  logic [ffa_pkg::REM_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [ffa_pkg::OFF_BITS-1:0]     val_q, val_d;
  logic [ffa_pkg::ALIGN_BITS-1:0]   rem_q, rem_d;
  logic [ffa_pkg::ALIGN_BITS-1:0]   div_q, div_d;
  logic [ffa_pkg::ALIGN_BITS:0]     trial;
  logic [ffa_pkg::ALIGN_BITS-1:0]   r_step;
  logic [ffa_pkg::OFF_BITS-1:0]     v_step;

  always_comb begin
    r_step = rem_q;
    v_step = val_q;
    trial  = '0;
    // The running remainder stays below the divisor, so it fits the divisor's width.
    for (int k = 0; k < ffa_pkg::REM_DIGITS; k++) begin
      trial  = {r_step, v_step[ffa_pkg::OFF_BITS-1]};
      v_step = {v_step[ffa_pkg::OFF_BITS-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        trial = trial - {1'b0, div_q};
      end
      r_step = trial[ffa_pkg::ALIGN_BITS-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    val_d  = val_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      val_d  = value_i;
      rem_d  = '0;
      div_d  = div_i;
    end else if (busy_q) begin
      val_d = v_step;
      rem_d = r_step;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ffa_pkg::REM_CNT_BITS'(ffa_pkg::REM_STEPS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

### hdl/ffa_datapath.sv
// Datapath of the allocator: free-list memory, pool registers, fit and merge
// arithmetic, result registers. Uses ffa_pkg, ffa_rem_unit and the assert header.
`default_nettype none

`include "first_fit_free_list_allocator_core_assert.svh"

module ffa_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ffa_pkg::dp_cmd_t                    cmd_i,
  output ffa_pkg::dp_stat_t                   stat_o,
  input  logic                                req_cmd_i,
  input  logic                                req_pool_i,
  input  logic [ffa_pkg::OFF_BITS-1:0]        req_bytes_i,
  input  logic [ffa_pkg::ALIGN_BITS-1:0]      req_align_i,
  input  logic [ffa_pkg::OFF_BITS-1:0]        req_offset_i,
  input  logic                                cfg_we_i,
  input  logic [ffa_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [ffa_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  output ffa_pkg::status_e                    out_status_o,
  output logic [ffa_pkg::OFF_BITS-1:0]        out_granted_o,
  output logic [ffa_pkg::CNT_BITS-1:0]        out_blocks_o
);

  localparam int OB = ffa_pkg::OFF_BITS;
  localparam int CB = ffa_pkg::CNT_BITS;
  localparam int SB = ffa_pkg::SLOT_BITS;
  localparam logic [CB-1:0] SLOTS_C = CB'(ffa_pkg::FREE_SLOTS);

  // Free-list memory: address is {pool, bank, slot}. Frees rebuild the list in
  // the other bank and flip it on success.
  logic [ffa_pkg::ENTRY_BITS-1:0] mem_q [ffa_pkg::MEM_DEPTH];
  logic [ffa_pkg::ENTRY_BITS-1:0] rdata_q;
  logic                           mem_we, mem_re;
  logic [ffa_pkg::MEM_AW-1:0]     waddr, raddr;
  logic [ffa_pkg::ENTRY_BITS-1:0] wdata;

  // Pool state.
  logic [CB-1:0] count_q [2], count_d [2];
  logic [OB-1:0] tail_q  [2], tail_d  [2];
  logic          bank_q  [2], bank_d  [2];
  logic [OB-1:0] cap_q   [2], cap_d   [2];

  // Request and work registers.
  logic                          cmd_q, cmd_d, pool_q, pool_d;
  logic [OB-1:0]                 bytes_q, bytes_d, off_q, off_d;
  logic [ffa_pkg::ALIGN_BITS-1:0] align_q, align_d;
  logic [CB-1:0]                 idx_q, idx_d, mv_q, mv_d, newc_q, newc_d, mcount_q, mcount_d;
  logic [OB-1:0]                 cur_s_q, cur_s_d, cur_l_q, cur_l_d, rv_q, rv_d;
  logic [OB-1:0]                 a_q, a_d, lead_q, lead_d, trail_q, trail_d;
  logic [1:0]                    nsplit_q, nsplit_d;
  logic [OB-1:0]                 last_s_q, last_s_d, last_l_q, last_l_d;
  logic                          placed_q, placed_d;
  ffa_pkg::status_e              p_status_q, p_status_d;
  logic [OB-1:0]                 p_granted_q, p_granted_d;
  ffa_pkg::status_e              out_status_q, out_status_d;
  logic [OB-1:0]                 out_granted_q, out_granted_d;
  logic [CB-1:0]                 out_blocks_q, out_blocks_d;

  // Remainder unit.
  logic                           rem_start, rem_busy;
  logic [OB-1:0]                  rem_val;
  logic [ffa_pkg::ALIGN_BITS-1:0] rem;

  ffa_rem_unit u_rem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rem_start),
    .value_i (rem_val),
    .div_i   (align_q),
    .busy_o  (rem_busy),
    .rem_o   (rem)
  );

  logic                           act_bank;
  logic [CB-1:0]                  cnt_cur;
  logic [ffa_pkg::ALIGN_BITS-1:0] add9;
  logic                           over;
  logic [OB:0]                    a33, end33, b33, cap33, trail33;
  logic [OB-1:0]                  lead32;
  logic [1:0]                     nsplit;
  logic [CB:0]                    newc_w;
  logic                           fit, split_full, tail_ok;
  logic [CB-1:0]                  idx_inc, mc_m1, tidx;
  logic                           do_push;
  logic [OB-1:0]                  push_s, push_l;
  logic [OB:0]                    lend33, pend33, nend33;
  logic                           push_merge;
  logic [OB-1:0]                  room_in;

  assign act_bank = bank_q[pool_q];
  assign cnt_cur  = count_q[pool_q];
  assign idx_inc  = idx_q + 1'b1;
  assign mc_m1    = mcount_q - 1'b1;

  // Rounding of rv_q up to a multiple of the alignment.
  assign add9  = (rem == '0) ? '0 : (align_q - rem);
  assign over  = {{(OB - ffa_pkg::ALIGN_BITS){1'b0}}, add9} > (ffa_pkg::OFF_MASK - rv_q);
  assign a33   = {1'b0, rv_q} + {{(OB + 1 - ffa_pkg::ALIGN_BITS){1'b0}}, add9};
  assign end33 = {1'b0, cur_s_q} + {1'b0, cur_l_q};
  assign b33   = {1'b0, bytes_q};
  assign cap33 = {1'b0, cap_q[pool_q]};

  assign fit     = !over && (a33 <= end33) && (b33 <= end33 - a33);
  assign tail_ok = !over && (a33 <= cap33) && (b33 <= cap33 - a33);
  assign lead32  = a33[OB-1:0] - cur_s_q;
  assign trail33 = end33 - a33 - b33;
  assign nsplit  = {1'b0, (lead32 != '0)} + {1'b0, (trail33 != '0)};
  assign newc_w  = {1'b0, cnt_cur} + {{(CB - 1){1'b0}}, nsplit} - 1'b1;
  assign split_full = newc_w > {1'b0, SLOTS_C};

  // Merge of one entry into the list being rebuilt.
  assign push_s     = (cmd_i.op == ffa_pkg::OP_F_PUSH) ? cur_s_q : off_q;
  assign push_l     = (cmd_i.op == ffa_pkg::OP_F_PUSH) ? cur_l_q : bytes_q;
  assign lend33     = {1'b0, last_s_q} + {1'b0, last_l_q};
  assign pend33     = {1'b0, push_s} + {1'b0, push_l};
  assign nend33     = (pend33 > lend33) ? pend33 : lend33;
  assign push_merge = (mcount_q != '0) && (lend33 >= {1'b0, push_s});

  assign room_in = ffa_pkg::OFF_MASK - req_offset_i;
  assign tidx    = idx_q + {{(CB - 1){1'b0}}, (lead_q != '0)};

  always_comb begin
    count_d = count_q;
    tail_d  = tail_q;
    bank_d  = bank_q;
    cap_d   = cap_q;
    cmd_d = cmd_q; pool_d = pool_q; bytes_d = bytes_q; off_d = off_q; align_d = align_q;
    idx_d = idx_q; mv_d = mv_q; newc_d = newc_q; mcount_d = mcount_q;
    cur_s_d = cur_s_q; cur_l_d = cur_l_q; rv_d = rv_q;
    a_d = a_q; lead_d = lead_q; trail_d = trail_q; nsplit_d = nsplit_q;
    last_s_d = last_s_q; last_l_d = last_l_q; placed_d = placed_q;
    p_status_d = p_status_q; p_granted_d = p_granted_q;
    out_status_d = out_status_q; out_granted_d = out_granted_q; out_blocks_d = out_blocks_q;
    mem_we = 1'b0; waddr = '0; wdata = '0;
    mem_re = 1'b0; raddr = '0;
    rem_start = 1'b0; rem_val = '0;
    do_push = 1'b0;

    if (cfg_we_i) begin
      if (cfg_idx_i == ffa_pkg::CFG_VERTEX_CAP) begin
        cap_d[ffa_pkg::POOL_VERTEX] = cfg_data_i[OB-1:0];
      end else if (cfg_idx_i == ffa_pkg::CFG_INDEX_CAP) begin
        cap_d[ffa_pkg::POOL_INDEX] = cfg_data_i[OB-1:0];
      end
    end

    unique case (cmd_i.op)
      ffa_pkg::OP_LATCH: begin
        cmd_d   = req_cmd_i;
        pool_d  = req_pool_i;
        off_d   = req_offset_i;
        align_d = (req_align_i == '0) ? ffa_pkg::ALIGN_BITS'(1) : req_align_i;
        // A freed block that would pass the top of the offset range is cut to end there.
        bytes_d = (req_cmd_i == ffa_pkg::CMD_FREE && req_bytes_i > room_in) ?
                  room_in : req_bytes_i;
        idx_d       = '0;
        mcount_d    = '0;
        placed_d    = 1'b0;
        p_status_d  = ffa_pkg::STATUS_OK;
        p_granted_d = '0;
      end
      ffa_pkg::OP_RD_ENTRY: begin
        mem_re = 1'b1;
        raddr  = {pool_q, act_bank, idx_q[SB-1:0]};
      end
      ffa_pkg::OP_LATCH_CUR: begin
        cur_s_d = rdata_q[ffa_pkg::ENTRY_BITS-1:OB];
        cur_l_d = rdata_q[OB-1:0];
        if (cmd_q == ffa_pkg::CMD_ALLOC) begin
          rem_start = 1'b1;
          rem_val   = rdata_q[ffa_pkg::ENTRY_BITS-1:OB];
          rv_d      = rdata_q[ffa_pkg::ENTRY_BITS-1:OB];
        end
      end
      ffa_pkg::OP_ALLOC_CHK: begin
        if (fit) begin
          if (split_full) begin
            p_status_d = ffa_pkg::STATUS_LIST_FULL;
          end else begin
            a_d         = a33[OB-1:0];
            p_granted_d = a33[OB-1:0];
            lead_d      = lead32;
            trail_d     = trail33[OB-1:0];
            nsplit_d    = nsplit;
            newc_d      = newc_w[CB-1:0];
            mv_d        = (nsplit == 2'd2) ? (cnt_cur - 1'b1) : idx_inc;
          end
        end else begin
          idx_d = idx_inc;
        end
      end
      ffa_pkg::OP_MV_RD: begin
        mem_re = 1'b1;
        raddr  = {pool_q, act_bank, mv_q[SB-1:0]};
      end
      ffa_pkg::OP_MV_WR: begin
        mem_we = 1'b1;
        wdata  = rdata_q;
        if (nsplit_q == 2'd2) begin
          waddr = {pool_q, act_bank, mv_q[SB-1:0] + 1'b1};
          mv_d  = mv_q - 1'b1;
        end else begin
          waddr = {pool_q, act_bank, mv_q[SB-1:0] - 1'b1};
          mv_d  = mv_q + 1'b1;
        end
      end
      ffa_pkg::OP_W_LEAD: begin
        if (lead_q != '0) begin
          mem_we = 1'b1;
          waddr  = {pool_q, act_bank, idx_q[SB-1:0]};
          wdata  = {cur_s_q, lead_q};
        end
      end
      ffa_pkg::OP_W_TRAIL: begin
        if (trail_q != '0) begin
          mem_we = 1'b1;
          waddr  = {pool_q, act_bank, tidx[SB-1:0]};
          wdata  = {a_q + bytes_q, trail_q};
        end
        count_d[pool_q] = newc_q;
      end
      ffa_pkg::OP_T_START: begin
        rem_start = 1'b1;
        rem_val   = tail_q[pool_q];
        rv_d      = tail_q[pool_q];
      end
      ffa_pkg::OP_T_CHK: begin
        if (tail_ok) begin
          tail_d[pool_q] = a33[OB-1:0] + bytes_q;
          p_granted_d    = a33[OB-1:0];
        end else begin
          p_status_d = ffa_pkg::STATUS_NO_SPACE;
        end
      end
      ffa_pkg::OP_F_INS: begin
        if (!placed_q && cur_s_q >= off_q) begin
          do_push  = 1'b1;
          placed_d = 1'b1;
        end
      end
      ffa_pkg::OP_F_PUSH: begin
        do_push = 1'b1;
        idx_d   = idx_inc;
      end
      ffa_pkg::OP_F_END: begin
        if (!placed_q) begin
          do_push = 1'b1;
        end
      end
      ffa_pkg::OP_F_FLUSH: begin
        if (mcount_q <= SLOTS_C) begin
          mem_we = 1'b1;
          waddr  = {pool_q, ~act_bank, mc_m1[SB-1:0]};
          wdata  = {last_s_q, last_l_q};
        end
        if (mcount_q > SLOTS_C) begin
          p_status_d = ffa_pkg::STATUS_LIST_FULL;
        end else begin
          count_d[pool_q] = mcount_q;
          bank_d[pool_q]  = ~act_bank;
        end
      end
      ffa_pkg::OP_FINISH: begin
        out_status_d  = p_status_q;
        out_granted_d = (p_status_q == ffa_pkg::STATUS_OK) ? p_granted_q : '0;
        out_blocks_d  = cnt_cur;
      end
      default: begin
      end
    endcase

    if (do_push) begin
      if (push_merge) begin
        last_l_d = OB'(nend33 - {1'b0, last_s_q});
      end else begin
        // The entry held so far is complete; it goes out to the spare bank.
        if (mcount_q != '0 && mcount_q <= SLOTS_C) begin
          mem_we = 1'b1;
          waddr  = {pool_q, ~act_bank, mc_m1[SB-1:0]};
          wdata  = {last_s_q, last_l_q};
        end
        if (mcount_q <= SLOTS_C) begin
          last_s_d = push_s;
          last_l_d = push_l;
          mcount_d = mcount_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < 2; p++) begin
        count_q[p] <= '0;
        tail_q[p]  <= '0;
        bank_q[p]  <= 1'b0;
        cap_q[p]   <= ffa_pkg::CAP_RESET;
      end
      out_status_q  <= ffa_pkg::STATUS_OK;
      out_granted_q <= '0;
      out_blocks_q  <= '0;
    end else begin
      count_q       <= count_d;
      tail_q        <= tail_d;
      bank_q        <= bank_d;
      cap_q         <= cap_d;
      out_status_q  <= out_status_d;
      out_granted_q <= out_granted_d;
      out_blocks_q  <= out_blocks_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; pool_q <= pool_d; bytes_q <= bytes_d; off_q <= off_d; align_q <= align_d;
    idx_q <= idx_d; mv_q <= mv_d; newc_q <= newc_d; mcount_q <= mcount_d;
    cur_s_q <= cur_s_d; cur_l_q <= cur_l_d; rv_q <= rv_d;
    a_q <= a_d; lead_q <= lead_d; trail_q <= trail_d; nsplit_q <= nsplit_d;
    last_s_q <= last_s_d; last_l_q <= last_l_d; placed_q <= placed_d;
    p_status_q <= p_status_d; p_granted_q <= p_granted_d;
  end

  always_comb begin
    stat_o.is_free    = (cmd_q == ffa_pkg::CMD_FREE);
    stat_o.count_zero = (cnt_cur == '0);
    stat_o.rem_busy   = rem_busy;
    stat_o.fit        = fit;
    stat_o.split_full = split_full;
    stat_o.idx_last   = (idx_inc == cnt_cur);
    unique case (nsplit_q)
      2'd2:    stat_o.mv_done = !(mv_q > idx_q);
      2'd0:    stat_o.mv_done = !(mv_q < cnt_cur);
      default: stat_o.mv_done = 1'b1;
    endcase
  end

  assign out_status_o  = out_status_q;
  assign out_granted_o = out_granted_q;
  assign out_blocks_o  = out_blocks_q;

  `FFA_ASSERT_IMPL(a_refusal_no_grant, out_status_q != ffa_pkg::STATUS_OK, out_granted_q == '0)
  `FFA_ASSERT_ALWAYS(a_count_bound, count_q[0] <= SLOTS_C && count_q[1] <= SLOTS_C)
  `FFA_ASSERT_IMPL(a_entry_read_before, cmd_i.op == ffa_pkg::OP_LATCH_CUR, $past(mem_re))

endmodule

`default_nettype wire

### hdl/ffa_ctrl.sv
// Controller of the allocator: sequences scan, split, tail and merge steps and
// owns the handshakes. Uses ffa_pkg command and status types.
`default_nettype none

module ffa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ffa_pkg::dp_stat_t stat_i,
  output ffa_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH,
    ST_A_RD, ST_A_WAIT, ST_A_MOD, ST_A_CHK,
    ST_MV_RD, ST_MV_WR, ST_W_LEAD, ST_W_TRAIL,
    ST_T_START, ST_T_MOD, ST_T_CHK,
    ST_F_RD, ST_F_WAIT, ST_F_INS, ST_F_PUSH, ST_F_END, ST_F_FLUSH,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = ffa_pkg::OP_NOP;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = ffa_pkg::OP_LATCH;
          state_d  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (stat_i.is_free) begin
          state_d = stat_i.count_zero ? ST_F_END : ST_F_RD;
        end else begin
          state_d = stat_i.count_zero ? ST_T_START : ST_A_RD;
        end
      end
      ST_A_RD: begin
        cmd_o.op = ffa_pkg::OP_RD_ENTRY;
        state_d  = ST_A_WAIT;
      end
      ST_A_WAIT: begin
        cmd_o.op = ffa_pkg::OP_LATCH_CUR;
        state_d  = ST_A_MOD;
      end
      ST_A_MOD: begin
        if (!stat_i.rem_busy) begin
          state_d = ST_A_CHK;
        end
      end
      ST_A_CHK: begin
        cmd_o.op = ffa_pkg::OP_ALLOC_CHK;
        if (stat_i.fit) begin
          state_d = stat_i.split_full ? ST_DONE : ST_MV_RD;
        end else begin
          state_d = stat_i.idx_last ? ST_T_START : ST_A_RD;
        end
      end
      ST_MV_RD: begin
        if (stat_i.mv_done) begin
          state_d = ST_W_LEAD;
        end else begin
          cmd_o.op = ffa_pkg::OP_MV_RD;
          state_d  = ST_MV_WR;
        end
      end
      ST_MV_WR: begin
        cmd_o.op = ffa_pkg::OP_MV_WR;
        state_d  = ST_MV_RD;
      end
      ST_W_LEAD: begin
        cmd_o.op = ffa_pkg::OP_W_LEAD;
        state_d  = ST_W_TRAIL;
      end
      ST_W_TRAIL: begin
        cmd_o.op = ffa_pkg::OP_W_TRAIL;
        state_d  = ST_DONE;
      end
      ST_T_START: begin
        cmd_o.op = ffa_pkg::OP_T_START;
        state_d  = ST_T_MOD;
      end
      ST_T_MOD: begin
        if (!stat_i.rem_busy) begin
          state_d = ST_T_CHK;
        end
      end
      ST_T_CHK: begin
        cmd_o.op = ffa_pkg::OP_T_CHK;
        state_d  = ST_DONE;
      end
      ST_F_RD: begin
        cmd_o.op = ffa_pkg::OP_RD_ENTRY;
        state_d  = ST_F_WAIT;
      end
      ST_F_WAIT: begin
        cmd_o.op = ffa_pkg::OP_LATCH_CUR;
        state_d  = ST_F_INS;
      end
      ST_F_INS: begin
        cmd_o.op = ffa_pkg::OP_F_INS;
        state_d  = ST_F_PUSH;
      end
      ST_F_PUSH: begin
        cmd_o.op = ffa_pkg::OP_F_PUSH;
        state_d  = stat_i.idx_last ? ST_F_END : ST_F_RD;
      end
      ST_F_END: begin
        cmd_o.op = ffa_pkg::OP_F_END;
        state_d  = ST_F_FLUSH;
      end
      ST_F_FLUSH: begin
        cmd_o.op = ffa_pkg::OP_F_FLUSH;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        // The result register is reloaded only once the previous beat is gone.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = ffa_pkg::OP_FINISH;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_o.op == ffa_pkg::OP_FINISH) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench of first_fit_free_list_allocator_core.
// Depends on ffa_pkg, ffa_req_if, ffa_rsp_if and the allocator RTL.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        cmd;
    logic        pool;
    logic [31:0] bytes;
    logic [8:0]  align;
    logic [31:0] rel;
  } alloc_req_t;

  typedef struct {
    ffa_pkg::status_e status;
    logic [31:0]      granted;
    logic [6:0]       blocks;
  } alloc_rsp_t;

  typedef struct {
    logic [63:0] start;
    logic [63:0] len;
  } span_t;

  class alloc_scoreboard;
    localparam logic [63:0] TOP = 64'hFFFF_FFFF;
    span_t       spans[2][$];
    logic [63:0] tail[2];
    logic [63:0] cap[2];
    alloc_rsp_t  pending_rsp[$];
    int          mismatches;

    function new();
      tail[0] = 0;
      tail[1] = 0;
      cap[0] = 64'(ffa_pkg::CAP_RESET);
      cap[1] = 64'(ffa_pkg::CAP_RESET);
      mismatches = 0;
    endfunction

    function void set_capacity(logic pool, logic [31:0] value);
      cap[pool] = {32'h0, value};
    endfunction

    // Returns 1 when the rounded value would leave the offset range.
    function bit round_to(logic [63:0] v, logic [63:0] a, output logic [63:0] r);
      logic [63:0] add;
      r = v;
      if (v % a == 0) return 0;
      add = a - (v % a);
      if (add > TOP - v) return 1;
      r = v + add;
      return 0;
    endfunction

    function ffa_pkg::status_e allocate(logic p, logic [63:0] bytes, logic [63:0] a,
                                        output logic [63:0] grant);
      logic [63:0] off, last, st, lead, trail, c;
      int n;
      grant = 0;
      c = (cap[p] > TOP) ? TOP : cap[p];
      for (int i = 0; i < spans[p].size(); i++) begin
        off = spans[p][i].start;
        last = off + spans[p][i].len;
        if (round_to(off, a, st) || st > last || bytes > last - st) continue;
        lead = st - off;
        trail = last - st - bytes;
        n = (lead > 0) + (trail > 0);
        if (spans[p].size() - 1 + n > ffa_pkg::FREE_SLOTS) return ffa_pkg::STATUS_LIST_FULL;
        spans[p].delete(i);
        if (trail > 0) spans[p].insert(i, '{st + bytes, trail});
        if (lead > 0) spans[p].insert(i, '{off, lead});
        grant = st;
        return ffa_pkg::STATUS_OK;
      end
      if (!round_to(tail[p], a, st) && st <= c && bytes <= c - st) begin
        tail[p] = st + bytes;
        grant = st;
        return ffa_pkg::STATUS_OK;
      end
      return ffa_pkg::STATUS_NO_SPACE;
    endfunction

    function void merge_in(ref span_t m[$], input logic [63:0] s, logic [63:0] l);
      logic [63:0] e;
      if (m.size() > 0) begin
        e = m[$].start + m[$].len;
        if (e >= s) begin
          if (s + l > e) e = s + l;
          m[$].len = e - m[$].start;
          return;
        end
      end
      m.insert(m.size(), '{s, l});
    endfunction

    function ffa_pkg::status_e release_span(logic p, logic [63:0] off, logic [63:0] bytes);
      span_t m[$];
      bit placed;
      placed = 0;
      if (bytes > TOP - off) bytes = TOP - off;
      for (int i = 0; i < spans[p].size(); i++) begin
        if (!placed && spans[p][i].start >= off) begin
          merge_in(m, off, bytes);
          placed = 1;
        end
        merge_in(m, spans[p][i].start, spans[p][i].len);
      end
      if (!placed) merge_in(m, off, bytes);
      if (m.size() > ffa_pkg::FREE_SLOTS) return ffa_pkg::STATUS_LIST_FULL;
      spans[p] = m;
      return ffa_pkg::STATUS_OK;
    endfunction

    function alloc_rsp_t note_request(alloc_req_t r);
      alloc_rsp_t  x;
      logic [63:0] g, a;
      a = (r.align == 0) ? 64'd1 : {55'h0, r.align};
      if (r.cmd == ffa_pkg::CMD_ALLOC) x.status = allocate(r.pool, {32'h0, r.bytes}, a, g);
      else begin
        x.status = release_span(r.pool, {32'h0, r.rel}, {32'h0, r.bytes});
        g = 0;
      end
      x.granted = (x.status == ffa_pkg::STATUS_OK) ? g[31:0] : 32'h0;
      x.blocks = 7'(spans[r.pool].size());
      pending_rsp.insert(pending_rsp.size(), x);
      return x;
    endfunction

    function void check_result(logic [1:0] st, logic [31:0] g, logic [6:0] b);
      alloc_rsp_t x;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: status %0d", st);
        return;
      end
      x = pending_rsp.pop_front();
      if (st !== x.status || g !== x.granted || b !== x.blocks) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status %0d offset %h blocks %0d, got %0d %h %0d",
                   x.status, x.granted, x.blocks, st, g, b);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [ffa_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [ffa_pkg::CFG_DATA_BITS-1:0] cfg_data_i;

  ffa_req_if req_bus ();
  ffa_rsp_if rsp_bus ();

  first_fit_free_list_allocator_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_bus.sink),
    .rsp_o      (rsp_bus.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  alloc_scoreboard sb = new();
  alloc_req_t      live_blocks[$];
  int              rsp_beats = 0;
  bit              stim_done = 0;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #60ms;
    $display("tb: failure");
    $finish;
  end

  task automatic send_request(alloc_req_t r);
    int gap;
    alloc_rsp_t x;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid <= 1'b1;
    req_bus.cmd <= r.cmd;
    req_bus.pool_select <= r.pool;
    req_bus.byte_count <= r.bytes;
    req_bus.align_bytes <= r.align;
    req_bus.release_offset <= r.rel;
    do @(posedge clk_i); while (!req_bus.ready);
    x = sb.note_request(r);
    if (r.cmd == ffa_pkg::CMD_ALLOC && x.status == ffa_pkg::STATUS_OK &&
        $urandom_range(0, 9) != 0) begin
      r.rel = x.granted;
      live_blocks.insert(live_blocks.size(), r);
    end
  endtask

  task automatic write_capacity(logic [ffa_pkg::CFG_IDX_BITS-1:0] idx, logic [31:0] value);
    // The block finishes one request per result, so an empty store means idle.
    req_bus.valid <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_capacity(idx == ffa_pkg::CFG_VERTEX_CAP ? ffa_pkg::POOL_VERTEX :
                    ffa_pkg::POOL_INDEX, value);
  endtask

  function automatic alloc_req_t make_req(logic cmd, logic pool, logic [31:0] bytes,
                                          logic [8:0] align, logic [31:0] rel);
    alloc_req_t r;
    r.cmd = cmd;
    r.pool = pool;
    r.bytes = bytes;
    r.align = align;
    r.rel = rel;
    return r;
  endfunction

  function automatic alloc_req_t random_req();
    alloc_req_t r;
    int k, pick;
    k = $urandom_range(0, 99);
    r = make_req(ffa_pkg::CMD_ALLOC, 1'($urandom_range(0, 1)), $urandom_range(0, 4096),
                 9'(1 << $urandom_range(0, 8)), $urandom);
    if ($urandom_range(0, 3) == 0) r.align = 9'($urandom_range(0, 256));
    if ($urandom_range(0, 19) == 0) r.bytes = $urandom;
    if (k >= 55 && k < 90 && live_blocks.size() > 0) begin
      // Return a block that was granted earlier, now and then only part of it.
      pick = $urandom_range(0, live_blocks.size() - 1);
      r = live_blocks[pick];
      live_blocks.delete(pick);
      r.cmd = ffa_pkg::CMD_FREE;
      if ($urandom_range(0, 4) == 0) r.bytes = r.bytes / 2;
    end else if (k >= 90) begin
      r.cmd = ffa_pkg::CMD_FREE;
      r.rel = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 1 << 20);
      r.bytes = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 64);
    end
    return r;
  endfunction

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    req_bus.valid = 1'b0;
    req_bus.cmd = ffa_pkg::CMD_ALLOC;
    req_bus.pool_select = ffa_pkg::POOL_INDEX;
    req_bus.byte_count = '0;
    req_bus.align_bytes = 9'd1;
    req_bus.release_offset = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners: zero alignment and size, odd alignment, oversize requests,
    // frees at the top of the range, rounding past the range, zero-length entries.
    send_request(make_req(ffa_pkg::CMD_ALLOC, ffa_pkg::POOL_INDEX, 32'd0, 9'd0, 32'd0));
    send_request(make_req(ffa_pkg::CMD_ALLOC, ffa_pkg::POOL_INDEX, 32'd100, 9'd3, 32'd0));
    send_request(make_req(ffa_pkg::CMD_ALLOC, ffa_pkg::POOL_VERTEX, 32'hFFFF_FFFF, 9'd1,
                          32'd0));
    send_request(make_req(ffa_pkg::CMD_ALLOC, ffa_pkg::POOL_VERTEX, 32'd7, 9'd256, 32'd0));
    send_request(make_req(ffa_pkg::CMD_FREE, ffa_pkg::POOL_INDEX, 32'd50, 9'd1, 32'd0));
    send_request(make_req(ffa_pkg::CMD_ALLOC, ffa_pkg::POOL_INDEX, 32'd10, 9'd256, 32'd0));
    send_request(make_req(ffa_pkg::CMD_ALLOC, ffa_pkg::POOL_INDEX, 32'd10, 9'd7, 32'd0));
    send_request(make_req(ffa_pkg::CMD_FREE, ffa_pkg::POOL_VERTEX, 32'd100, 9'd1,
                          32'hFFFF_FFF0));
    send_request(make_req(ffa_pkg::CMD_ALLOC, ffa_pkg::POOL_VERTEX, 32'd1, 9'd256, 32'd0));
    send_request(make_req(ffa_pkg::CMD_ALLOC, ffa_pkg::POOL_VERTEX, 32'd15, 9'd1, 32'd0));
    send_request(make_req(ffa_pkg::CMD_FREE, ffa_pkg::POOL_INDEX, 32'd0, 9'd1, 32'd500));
    send_request(make_req(ffa_pkg::CMD_ALLOC, ffa_pkg::POOL_INDEX, 32'd0, 9'd0, 32'd0));
    send_request(make_req(ffa_pkg::CMD_FREE, ffa_pkg::POOL_INDEX, 32'd40, 9'd1, 32'd30));
    send_request(make_req(ffa_pkg::CMD_FREE, ffa_pkg::POOL_INDEX, 32'hFFFF_FFFF, 9'd1,
                          32'h8000_0000));
    send_request(make_req(ffa_pkg::CMD_ALLOC, ffa_pkg::POOL_INDEX, 32'h7FFF_FFFF, 9'd256,
                          32'd0));
    send_request(make_req(ffa_pkg::CMD_ALLOC, ffa_pkg::POOL_VERTEX, 32'h03FF_FFF0, 9'd256,
                          32'd0));

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_capacity(ffa_pkg::CFG_VERTEX_CAP, 32'd0);
          write_capacity(ffa_pkg::CFG_INDEX_CAP, 32'hFFFF_FFFF);
        end
        1: begin
          write_capacity(ffa_pkg::CFG_VERTEX_CAP, 32'hFFFF_FFFF);
          write_capacity(ffa_pkg::CFG_INDEX_CAP, 32'd4096);
        end
        2: begin
          write_capacity(ffa_pkg::CFG_VERTEX_CAP, $urandom_range(0, 1 << 16));
          write_capacity(ffa_pkg::CFG_INDEX_CAP, $urandom);
        end
        default: begin
          write_capacity(ffa_pkg::CFG_VERTEX_CAP, 32'(ffa_pkg::CAP_RESET));
          write_capacity(ffa_pkg::CFG_INDEX_CAP, 32'(ffa_pkg::CAP_RESET));
        end
      endcase
      repeat (250) send_request(random_req());
    end
    req_bus.valid <= 1'b0;
    stim_done = 1;
  end

  initial begin
    int gap;
    rsp_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) gap = 0;
      // One long hold-off so the output register fills and the input stalls.
      if (rsp_beats == 120) gap = 400;
      if (gap > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_bus.valid);
      rsp_beats++;
      sb.check_result(rsp_bus.status, rsp_bus.granted_offset, rsp_bus.free_blocks);
    end
  end

  initial begin
    @(posedge clk_i);
    while (!(stim_done && sb.pending_rsp.size() == 0)) @(posedge clk_i);
    repeat (1000) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_rsp.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

`default_nettype wire
